>>> hdl/rpn_pkg.sv
// Shared types and constants for the RPN stack calculator.
package rpn_pkg;

	localparam int DATA_W  = 32;
	localparam int OP_W    = 4;
	localparam int DEPTH_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH    = 4'd0,
		OP_ADD     = 4'd1,
		OP_SUB     = 4'd2,
		OP_MUL     = 4'd3,
		OP_DIV     = 4'd4,
		OP_DUP     = 4'd5,
		OP_INC     = 4'd6,
		OP_DEC     = 4'd7,
		OP_INSPECT = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_DIV0  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_OPER,
		S_MULW,
		S_DIVW,
		S_RESP
	} ctrl_state_t;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] push_value;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] top_value;
		logic [DEPTH_W-1:0]       stack_depth;
		logic [1:0]               status;
	} out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    push;
		logic    dup;
		logic    inc;
		logic    dec;
		logic    rd_second;
		logic    alu_wr;
		logic    mul_cap;
		logic    mul_wr;
		logic    div_start;
		logic    div_wr;
		logic    status_we;
		status_t status;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            count_zero;
		logic            count_lt2;
		logic            count_full;
		logic            second_zero;
		logic            div_done;
	} dp_stat_t;

endpackage

>>> hdl/rpn_div.sv
// Radix-2 restoring signed divider, quotient truncated toward zero.
module rpn_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [rpn_pkg::DATA_W-1:0]       dividend,
	input  logic [rpn_pkg::DATA_W-1:0]       divisor,
	output logic                             done,
	output logic [rpn_pkg::DATA_W-1:0]       quotient
);
	import rpn_pkg::*;

	localparam int CW = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic              neg_q;
	logic [DATA_W:0]   trial;
	logic              last_step;

	// Trial subtraction of the divisor from the partial remainder.
	assign trial = {rem_q, quo_q[DATA_W-1]} - {1'b0, dvs_q};

	// The last quotient bit is being formed in this cycle.
	assign last_step = busy_q && (cnt_q == CW'(DATA_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
			dvs_q <= divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + DATA_W'(1)) : quo_q;

endmodule

>>> hdl/rpn_dp.sv
// Datapath: cached top of stack, stack memory, arithmetic and result register.
module rpn_dp #(
	parameter int STACK_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rpn_pkg::in_t     command,
	input  rpn_pkg::dp_cmd_t cmd,
	output rpn_pkg::dp_stat_t stat,
	output rpn_pkg::out_t    result
);
	import rpn_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int AW    = $clog2(STACK_DEPTH);

	// Entries below the top live in memory; the top entry lives in top_q.
	logic [DATA_W-1:0] mem [STACK_DEPTH];

	logic [CNT_W-1:0]   count_q;
	logic [DATA_W-1:0]  top_q;
	logic [DATA_W-1:0]  second_q;
	logic [DATA_W-1:0]  prod_q;
	logic [OP_W-1:0]    op_q;
	logic [DATA_W-1:0]  pv_q;
	status_t            status_q;
	logic [CNT_W-1:0]   cnt_m1;
	logic [CNT_W-1:0]   cnt_m2;
	logic [DATA_W-1:0]  quotient;
	logic               div_done;
	logic               count_zero;
	logic [DEPTH_W+CNT_W-1:0] depth_wide;

	assign cnt_m1     = count_q - CNT_W'(1);
	assign cnt_m2     = count_q - CNT_W'(2);
	assign count_zero = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			if (cmd.push || cmd.dup) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.alu_wr || cmd.mul_wr || cmd.div_wr) begin
				count_q <= cnt_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= command.op;
			pv_q     <= command.push_value;
			status_q <= ST_OK;
		end else if (cmd.status_we) begin
			status_q <= cmd.status;
		end
		// Push and dup spill the old top into memory below the new top.
		if ((cmd.push || cmd.dup) && !count_zero) begin
			mem[cnt_m1[AW-1:0]] <= top_q;
		end
		if (cmd.rd_second) begin
			second_q <= mem[cnt_m2[AW-1:0]];
		end
		if (cmd.mul_cap) begin
			prod_q <= top_q * second_q;
		end
		priority if (cmd.push) begin
			top_q <= pv_q;
		end else if (cmd.inc) begin
			top_q <= top_q + DATA_W'(1);
		end else if (cmd.dec) begin
			top_q <= top_q - DATA_W'(1);
		end else if (cmd.alu_wr) begin
			top_q <= (op_q == OP_ADD) ? (top_q + second_q) : (top_q - second_q);
		end else if (cmd.mul_wr) begin
			top_q <= prod_q;
		end else if (cmd.div_wr) begin
			top_q <= quotient;
		end else begin
			top_q <= top_q;
		end
	end

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (top_q),
		.divisor  (second_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign stat.op          = op_q;
	assign stat.count_zero  = count_zero;
	assign stat.count_lt2   = (count_q < CNT_W'(2));
	assign stat.count_full  = (count_q >= CNT_W'(STACK_DEPTH));
	assign stat.second_zero = (second_q == '0);
	assign stat.div_done    = div_done;

	// The reported depth is the count modulo 32.
	assign depth_wide = {{DEPTH_W{1'b0}}, count_q};

	assign result.top_value   = count_zero ? '0 : top_q;
	assign result.stack_depth = depth_wide[DEPTH_W-1:0];
	assign result.status      = status_q;

endmodule

>>> hdl/rpn_ctrl.sv
// Controller state machine that sequences one command through the datapath.
module rpn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rpn_pkg::dp_stat_t stat,
	output rpn_pkg::dp_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	import rpn_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        is_binop;

	assign is_binop = (stat.op == OP_ADD) || (stat.op == OP_SUB) ||
	                  (stat.op == OP_MUL) || (stat.op == OP_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (is_binop && !stat.count_lt2) state_d = S_OPER;
				else state_d = S_RESP;
			end
			S_OPER: begin
				if (stat.op == OP_MUL) state_d = S_MULW;
				else if (stat.op == OP_DIV && !stat.second_zero) state_d = S_DIVW;
				else state_d = S_RESP;
			end
			S_MULW: begin
				state_d = S_RESP;
			end
			S_DIVW: begin
				if (stat.div_done) state_d = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != S_IDLE);
		done = (state_q == S_RESP);
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
			end
			S_DECODE: begin
				unique case (stat.op)
					OP_PUSH: begin
						if (stat.count_full) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_OVER;
						end else begin
							cmd.push = 1'b1;
						end
					end
					OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
						if (stat.count_lt2) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_UNDER;
						end else begin
							cmd.rd_second = 1'b1;
						end
					end
					OP_DUP: begin
						if (stat.count_zero) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_UNDER;
						end else if (stat.count_full) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_OVER;
						end else begin
							cmd.dup = 1'b1;
						end
					end
					OP_INC, OP_DEC: begin
						if (stat.count_zero) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_UNDER;
						end else begin
							cmd.inc = (stat.op == OP_INC);
							cmd.dec = (stat.op == OP_DEC);
						end
					end
					default: begin
						// Inspect and every unused code only report the top.
						if (stat.count_zero) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_UNDER;
						end
					end
				endcase
			end
			S_OPER: begin
				if (stat.op == OP_MUL) begin
					cmd.mul_cap = 1'b1;
				end else if (stat.op == OP_DIV) begin
					if (stat.second_zero) begin
						cmd.status_we = 1'b1;
						cmd.status    = ST_DIV0;
					end else begin
						cmd.div_start = 1'b1;
					end
				end else begin
					cmd.alu_wr = 1'b1;
				end
			end
			S_MULW: begin
				cmd.mul_wr = 1'b1;
			end
			S_DIVW: begin
				cmd.div_wr = stat.div_done;
			end
			S_RESP: begin
				cmd = '0;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> hdl/rpn_stack_calculator_unit.sv
// Top level of the RPN stack calculator: controller, datapath and divider.
//
// Usage: the host drives a command (op and push_value) and raises start while
// busy is low; that edge accepts the transaction. busy then stays high until
// the result has been delivered. The result (new top of stack, depth and
// status) appears on the result port for exactly one cycle with done high,
// and is taken at the clock edge that ends that cycle. The receiver cannot
// stall the block, so there is no backpressure on the result side.
//
// Sequence after the accepting edge: push, dup, inc, dec, inspect and every
// failing command other than divide by zero go from decode to the response
// state; add, subtract and divide by zero pass through the operate state;
// multiply also passes through a multiply-write state; divide waits for
// the radix-2 divider, one quotient bit per cycle. One command is in flight
// at a time, so a new transaction can be accepted the cycle after done.
//
// Reset (arst_n low, asynchronous) empties the stack and returns the
// controller to idle. Stack memory is not cleared; only entries that were
// pushed are ever read.
module rpn_stack_calculator_unit #(
	parameter int STACK_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rpn_pkg::in_t  command,
	output logic          busy,
	output logic          done,
	output rpn_pkg::out_t result
);
	import rpn_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The controller decides what each cycle does from the datapath flags.
	rpn_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// The datapath holds the stack, latches the command and forms the result.
	rpn_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.command (command),
		.cmd     (cmd),
		.stat    (stat),
		.result  (result)
	);

endmodule

>>> tb/sv/rpn_calc_checker.sv
// Checker for the RPN stack calculator: predicts each command's outcome and compares results.
module rpn_calc_checker #(
	parameter int STACK_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  rpn_pkg::in_t  command,
	input  logic          done,
	input  rpn_pkg::out_t result,
	output int            fail_count,
	output int            outstanding
);
	import rpn_pkg::*;

	localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] ONE      = 1;

	// Private copy of the calculator's stack.
	logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
	int unsigned       shadow_depth = 0;

	out_t stack_outcomes [$];
	int   errors       = 0;
	int   result_count = 0;

	task automatic report_error(string msg);
		$display("rpn checker: %s", msg);
		errors++;
	endtask

	// Applies one command to the shadow stack and returns the outcome it must produce.
	function automatic out_t execute_rpn(in_t cmd);
		logic [DATA_W-1:0] t;
		logic [DATA_W-1:0] s;
		logic [DATA_W-1:0] r;
		status_t           st;
		out_t              res;
		st = ST_OK;
		t  = '0;
		s  = '0;
		r  = '0;
		if (shadow_depth > 0) t = shadow_stack[shadow_depth-1];
		if (shadow_depth > 1) s = shadow_stack[shadow_depth-2];
		case (cmd.op)
			OP_PUSH: begin
				if (shadow_depth >= STACK_DEPTH) begin
					st = ST_OVER;
				end else begin
					shadow_stack[shadow_depth] = cmd.push_value;
					shadow_depth++;
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (shadow_depth < 2) begin
					st = ST_UNDER;
				end else if (cmd.op == OP_DIV && s == '0) begin
					st = ST_DIV0;
				end else begin
					case (cmd.op)
						OP_ADD: r = t + s;
						OP_SUB: r = t - s;
						OP_MUL: r = t * s;
						default: begin
							// The one quotient that does not fit wraps back to itself.
							if (t == MOST_NEG && s == '1) r = MOST_NEG;
							else r = $signed(t) / $signed(s);
						end
					endcase
					shadow_depth--;
					shadow_stack[shadow_depth-1] = r;
				end
			end
			OP_DUP: begin
				if (shadow_depth == 0) begin
					st = ST_UNDER;
				end else if (shadow_depth >= STACK_DEPTH) begin
					st = ST_OVER;
				end else begin
					shadow_stack[shadow_depth] = t;
					shadow_depth++;
				end
			end
			OP_INC, OP_DEC: begin
				if (shadow_depth == 0) st = ST_UNDER;
				else if (cmd.op == OP_INC) shadow_stack[shadow_depth-1] = t + ONE;
				else shadow_stack[shadow_depth-1] = t - ONE;
			end
			default: begin
				// Inspect, and every unassigned code along with it.
				if (shadow_depth == 0) st = ST_UNDER;
			end
		endcase
		res.top_value   = (shadow_depth > 0) ? shadow_stack[shadow_depth-1] : '0;
		res.stack_depth = shadow_depth[DEPTH_W-1:0];
		res.status      = st;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			shadow_depth = 0;
			stack_outcomes.delete();
		end else begin
			// A result always belongs to an earlier transaction, so it is retired first.
			if (done) begin
				if (stack_outcomes.size() == 0) begin
					report_error($sformatf("result %0d arrived with nothing outstanding",
						result_count));
				end else begin
					want = stack_outcomes.pop_front();
					if (result.top_value !== want.top_value)
						report_error($sformatf("result %0d top_value %h, expected %h",
							result_count, result.top_value, want.top_value));
					if (result.stack_depth !== want.stack_depth)
						report_error($sformatf("result %0d stack_depth %0d, expected %0d",
							result_count, result.stack_depth, want.stack_depth));
					if (result.status !== want.status)
						report_error($sformatf("result %0d status %0d, expected %0d",
							result_count, result.status, want.status));
				end
				result_count++;
			end
			if (start && !busy) stack_outcomes.push_back(execute_rpn(command));
		end
		outstanding <= stack_outcomes.size();
		fail_count  <= errors;
	end

endmodule

>>> tb/sv/tb_rpn_stack_calculator_unit.sv
// Testbench top for the RPN stack calculator: command stimulus, clock, reset and verdict.
module tb_rpn_stack_calculator_unit;
	import rpn_pkg::*;

	localparam int          STACK_DEPTH  = 16;
	localparam int          RANDOM_ITEMS = 1700;
	// Every this many random commands the sequence mood changes, and now and
	// then the sender waits for the block to empty out completely.
	localparam int          BLOCK_LEN    = 40;
	localparam int          DRAIN_EVERY  = 400;
	// Long enough for the slowest command (divide) to finish, so this covers the tail.
	localparam int          TAIL_CYCLES  = 60;
	// Worst case per command: divide latency plus the longest sender gap,
	// times all commands, taken several times over.
	localparam int unsigned CYCLE_LIMIT  = 600000;

	// Op codes without a meaning of their own; the block treats them as inspect.
	localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd9;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

	localparam logic [DATA_W-1:0] MOST_POS = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;

	logic clk     = 1'b0;
	logic arst_n  = 1'b0;
	logic start   = 1'b0;
	in_t  command = '0;
	logic busy;
	logic done;
	out_t result;

	int          fail_count;
	int          outstanding;
	int unsigned cycle_count = 0;

	// The opening sequence walks through the corner cases in an order where
	// each step depends on the stack left by the ones before it:
	// inspect, add, dup, inc and dec on an empty stack (all underflow), a
	// binary op with a single entry, the most negative value divided by minus
	// one, a divide by zero on a three-deep stack, increment wrapping past
	// the most positive value, a multiply that wraps to zero, the unassigned
	// op codes, and a division that truncates toward zero.
	in_t opening_seq [24] = '{
		'{OP_INSPECT, 32'h0000_0000},
		'{OP_ADD,     32'h0000_0000},
		'{OP_DUP,     32'hffff_ffff},
		'{OP_INC,     32'h0000_0000},
		'{OP_DEC,     32'h0000_0000},
		'{OP_PUSH,    32'hffff_ffff},
		'{OP_DIV,     32'h0000_0000},
		'{OP_PUSH,    MOST_NEG},
		'{OP_DIV,     32'h0000_0000},
		'{OP_PUSH,    32'h0000_0000},
		'{OP_PUSH,    MOST_POS},
		'{OP_DIV,     32'h0000_0000},
		'{OP_INC,     32'h0000_0000},
		'{OP_SUB,     32'h0000_0000},
		'{OP_MUL,     32'h0000_0000},
		'{OP_DEC,     32'h0000_0000},
		'{OP_DUP,     32'h0000_0000},
		'{OP_ADD,     32'h0000_0000},
		'{OP_SPARE_LO, 32'h1234_5678},
		'{OP_SPARE_HI, 32'h0000_0000},
		'{OP_PUSH,    32'h5555_5555},
		'{OP_PUSH,    32'haaaa_aaaa},
		'{OP_DIV,     32'h0000_0000},
		'{OP_SUB,     32'h0000_0000}
	};

	always #10 clk = ~clk;

	rpn_stack_calculator_unit #(
		.STACK_DEPTH(STACK_DEPTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.command(command),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	rpn_calc_checker #(
		.STACK_DEPTH(STACK_DEPTH)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.done       (done),
		.result     (result),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	// Watchdog: a hung handshake or a result that never comes ends up here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Offers one transaction and returns at the edge that accepts it. The
	// gap is the number of cycles start stays low first; with no gap, start
	// simply stays high and only the command changes, so start never gets
	// two assignments in one time step. Start is left high on return, but the
	// next falling edge always replaces the command or lowers start before
	// the block can take the stale one.
	task automatic send_command(in_t cmd, int unsigned gap);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start   <= 1'b1;
		command <= cmd;
		do @(posedge clk); while (busy);
	endtask

	// Holds the sender off until every outstanding transaction has returned.
	// The first wait lets the checker's count catch up with the last accept.
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		int unsigned       mood;
		bit                idling;
		int unsigned       roll;
		int unsigned       gap;
		int unsigned       push_cut;
		int unsigned       dup_cut;
		in_t               cmd;

		mood     = 0;
		idling   = 1'b1;
		push_cut = 0;
		dup_cut  = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (opening_seq[i]) send_command(opening_seq[i], $urandom_range(0, 2));
		wait_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % DRAIN_EVERY == DRAIN_EVERY - 1) wait_drained();

			// Each block of commands gets a mood: growing the stack until it
			// overflows, staying around the middle, or shrinking it into
			// underflow. Some blocks also run back to back with no idling.
			if (n % BLOCK_LEN == 0) begin
				mood   = $urandom_range(0, 2);
				idling = ($urandom_range(0, 3) != 0);
				case (mood)
					0: begin
						push_cut = 55;
						dup_cut  = 75;
					end
					1: begin
						push_cut = 35;
						dup_cut  = 45;
					end
					default: begin
						push_cut = 15;
						dup_cut  = 20;
					end
				endcase
			end

			roll = $urandom_range(0, 99);
			if (roll < push_cut) cmd.op = OP_PUSH;
			else if (roll < dup_cut) cmd.op = OP_DUP;
			else if (roll < 95) cmd.op = OP_W'($urandom_range(OP_ADD, OP_INSPECT));
			else cmd.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));

			// Extremes, zero and small values keep divide by zero, the most
			// negative quotient and the wrap-arounds coming up often.
			case ($urandom_range(0, 9))
				0: cmd.push_value = MOST_NEG;
				1: cmd.push_value = MOST_POS;
				2: cmd.push_value = '0;
				3: cmd.push_value = '1;
				4, 5: cmd.push_value = $signed($urandom_range(0, 16)) - 8;
				default: cmd.push_value = $urandom;
			endcase

			// Mostly short gaps, a few long ones.
			if (!idling) gap = 0;
			else if ($urandom_range(0, 9) == 0) gap = $urandom_range(8, 40);
			else gap = $urandom_range(0, 3);

			send_command(cmd, gap);
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
